/* design/block_energy_onset_detector_defines.svh */
// Assertion macros used by the checker file.
`ifndef BLOCK_ENERGY_ONSET_DETECTOR_DEFINES_SVH
`define BLOCK_ENERGY_ONSET_DETECTOR_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define BEDO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define BEDO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset cycles.
`define BEDO_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bedo_pkg.sv */
// Package for the block energy onset detector: sizes, codes and word types.
package bedo_pkg;

  localparam int BLOCK_SIZE   = 256;
  localparam int POS_BITS     = 24;
  localparam int OUT_POS_BITS = 24;
  localparam int OFF_BITS     = (BLOCK_SIZE > 2) ? $clog2(BLOCK_SIZE) : 1;
  localparam int ENERGY_BITS  = 40;
  localparam int PREV10_BITS  = ENERGY_BITS + 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int SQ_BITS      = 2 * SAMPLE_BITS - 1;

  localparam logic [ENERGY_BITS-1:0] THRESHOLD_RESET = 40'd2748779069;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_ONSET = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic [OUT_POS_BITS-1:0] marker_position;
    logic                    kind;
  } out_word_t;

  // Registered sample handed to the accumulator.
  typedef struct packed {
    logic               adv;
    logic [SQ_BITS-1:0] sq;
    logic               zero;
    logic               last;
  } step_t;

  typedef struct packed {
    logic      emit;
    out_word_t word;
  } res_t;

endpackage

/* design/bedo_accum.sv */
// Block energy accumulator, zero tracker and onset decision.
module bedo_accum
  import bedo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  step_t                  step,
  input  logic [ENERGY_BITS-1:0] thr,
  output res_t                   res
);

  logic [POS_BITS-1:0]    base_r, base_nxt;
  logic [OFF_BITS-1:0]    offset_r, offset_nxt;
  logic [OFF_BITS-1:0]    zoff_r, zoff_nxt;
  logic                   found_r, found_nxt;
  logic                   started_r, started_nxt;
  logic [ENERGY_BITS-1:0] energy_r, energy_nxt;
  logic [ENERGY_BITS-1:0] prev_r, prev_nxt;
  logic [PREV10_BITS-1:0] prev10_r, prev10_nxt;

  logic [OFF_BITS-1:0]    zoff_sel;
  logic                   found_sel;
  logic [ENERGY_BITS:0]   sum_ext;
  logic [ENERGY_BITS-1:0] energy_sat;
  logic                   blk_end;
  logic                   onset;
  logic [POS_BITS-1:0]    pos;

  always_comb begin
    zoff_sel   = (step.zero && !found_r) ? offset_r : zoff_r;
    found_sel  = found_r | step.zero;
    sum_ext    = {1'b0, energy_r} + (ENERGY_BITS+1)'(step.sq);
    energy_sat = sum_ext[ENERGY_BITS] ? '1 : sum_ext[ENERGY_BITS-1:0];
    blk_end    = (offset_r == OFF_BITS'(BLOCK_SIZE - 1));
    onset      = blk_end && !step.last && started_r && (energy_sat > thr) &&
                 ({4'b0000, energy_sat} > prev10_r);
    pos        = base_r + POS_BITS'(zoff_sel);

    res.emit = !started_r || onset;
    res.word.kind            = started_r ? KIND_ONSET : KIND_START;
    res.word.marker_position = started_r ? OUT_POS_BITS'(pos) : '0;
  end

  always_comb begin
    base_nxt    = base_r;
    offset_nxt  = offset_r;
    zoff_nxt    = zoff_r;
    found_nxt   = found_r;
    started_nxt = started_r;
    energy_nxt  = energy_r;
    prev_nxt    = prev_r;
    if (step.adv) begin
      if (step.last) begin
        base_nxt    = '0;
        offset_nxt  = '0;
        zoff_nxt    = '0;
        found_nxt   = 1'b0;
        started_nxt = 1'b0;
        energy_nxt  = '0;
        prev_nxt    = '0;
      end else if (blk_end) begin
        started_nxt = 1'b1;
        prev_nxt    = energy_sat;
        energy_nxt  = '0;
        zoff_nxt    = '0;
        found_nxt   = 1'b0;
        offset_nxt  = '0;
        base_nxt    = base_r + POS_BITS'(BLOCK_SIZE);
      end else begin
        started_nxt = 1'b1;
        energy_nxt  = energy_sat;
        zoff_nxt    = zoff_sel;
        found_nxt   = found_sel;
        offset_nxt  = offset_r + 1'b1;
      end
    end
    // 10x previous energy is registered from prev_r; the next block end never
    // comes before prev10_r has followed a change of prev_r.
    prev10_nxt = ({4'b0000, prev_r} << 3) + ({4'b0000, prev_r} << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      offset_r  <= '0;
      zoff_r    <= '0;
      found_r   <= 1'b0;
      started_r <= 1'b0;
      energy_r  <= '0;
      prev_r    <= '0;
      prev10_r  <= '0;
    end else begin
      base_r    <= base_nxt;
      offset_r  <= offset_nxt;
      zoff_r    <= zoff_nxt;
      found_r   <= found_nxt;
      started_r <= started_nxt;
      energy_r  <= energy_nxt;
      prev_r    <= prev_nxt;
      prev10_r  <= prev10_nxt;
    end
  end

endmodule

/* design/block_energy_onset_detector.sv */
// Block energy onset detector: top level with input stage and output register.
//
// Input words (in_valid/in_stall) carry one signed 16-bit sample and a flag
// for the last sample of a buffer. Samples are grouped into fixed blocks; the
// sum of squares of each block is compared against cfg threshold and ten
// times the previous block's energy. An onset gives a marker at block start
// plus the offset of the first zero sample of the block. The first sample of
// each buffer gives a start marker at position 0. Zero or one result word per
// input word leaves on out_valid/out_stall.
// Throughput: one word per cycle while the output is not stalled. A result
// word passes the input stage (square registered with the input), then
// accumulate and decide into the output register.
// Reset clears all block state and the output valid flag and loads the
// threshold with its default. The last flag clears block state after that
// sample is handled; the threshold is kept.
// When the receiver stalls, the pending result holds and at most one more
// input word is taken into the input stage; further input is stalled until
// the result leaves. cfg_we writes the threshold; write it only while idle.
module block_energy_onset_detector
  import bedo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [ENERGY_BITS-1:0] cfg_wdata
);

  logic                   s1_v_r, s1_v_nxt;
  logic [SQ_BITS-1:0]     sq_r;
  logic                   zero_r;
  logic                   last_r;
  logic                   out_v_r, out_v_nxt;
  out_word_t              out_word_r;
  logic [ENERGY_BITS-1:0] thr_r;
  logic signed [2*SAMPLE_BITS-1:0] sq_full;
  logic                   in_acc;
  logic                   adv;
  step_t                  step;
  res_t                   res;

  assign adv      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign sq_full  = in_word.sample * in_word.sample;

  // the accumulator sees the registered word
  assign step.adv  = adv;
  assign step.sq   = sq_r;
  assign step.zero = zero_r;
  assign step.last = last_r;

  bedo_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .thr   (thr_r),
    .res   (res)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv && res.emit) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      thr_r   <= THRESHOLD_RESET;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_r   <= sq_full[SQ_BITS-1:0];
      zero_r <= (in_word.sample == '0);
      last_r <= in_word.last;
    end
    if (adv && res.emit) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

endmodule

/* design/bedo_checker.sv */
// Port-level checker for the block energy onset detector, bound to the top.
`include "block_energy_onset_detector_defines.svh"

module bedo_checker
  import bedo_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  `BEDO_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")
  `BEDO_ASSERT_IMP(a_start_pos, out_valid && (out_word.kind == KIND_START), out_word.marker_position == '0, "start marker not at zero")
  `BEDO_ASSERT_IMP(a_no_false_stall, !out_stall, !in_stall, "input stalled with free output")
  `BEDO_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind block_energy_onset_detector bedo_checker u_bedo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the block energy onset detector.
`timescale 1ns / 1ps

module testbench;
  import bedo_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [63:0] ENERGY_FULL = (64'd1 << ENERGY_BITS) - 64'd1;
  localparam logic [ENERGY_BITS-1:0] THRESHOLD_TOP = ENERGY_FULL[ENERGY_BITS-1:0];

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_word   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_we    = 1'b0;
  logic [ENERGY_BITS-1:0] cfg_wdata = '0;

  block_energy_onset_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Detector state as the testbench sees it.
  logic [ENERGY_BITS-1:0] threshold_reg;
  logic [POS_BITS-1:0]    block_start;
  logic [OFF_BITS-1:0]    block_pos;
  logic [ENERGY_BITS-1:0] block_energy;
  logic [ENERGY_BITS-1:0] last_energy;
  logic [OFF_BITS-1:0]    zero_pos;
  logic                   zero_seen;
  logic                   buffer_open;

  out_word_t expected_markers[$];
  int        mismatches   = 0;
  int        samples_sent = 0;
  int        quiet_cycles = 0;
  bit        idle_on      = 1'b1;
  bit        hold_request = 1'b0;
  int        stall_left   = 0;

  function automatic void clear_buffer();
    block_start  = '0;
    block_pos    = '0;
    block_energy = '0;
    last_energy  = '0;
    zero_pos     = '0;
    zero_seen    = 1'b0;
    buffer_open  = 1'b0;
  endfunction

  function automatic void predict_marker(input in_word_t w);
    logic [63:0]            sq;
    logic [63:0]            acc;
    logic [ENERGY_BITS+3:0] ten_last;
    logic [POS_BITS-1:0]    pos;
    logic                   gave_start;
    out_word_t              m;
    sq = 64'(longint'(w.sample) * longint'(w.sample));
    gave_start = 1'b0;
    if (!buffer_open) begin
      m.marker_position = '0;
      m.kind = KIND_START;
      expected_markers.insert(expected_markers.size(), m);
      buffer_open = 1'b1;
      gave_start = 1'b1;
    end
    if (w.sample == 0 && !zero_seen) begin
      zero_pos = block_pos;
      zero_seen = 1'b1;
    end
    acc = 64'(block_energy) + sq;
    block_energy = (acc > ENERGY_FULL) ? THRESHOLD_TOP : acc[ENERGY_BITS-1:0];
    if (block_pos == OFF_BITS'(BLOCK_SIZE - 1)) begin
      ten_last = (ENERGY_BITS+4)'(last_energy) * 10;
      // a block closing on the buffer's last word is never judged
      if (!w.last && !gave_start && block_energy > threshold_reg &&
          (ENERGY_BITS+4)'(block_energy) > ten_last) begin
        pos = block_start + POS_BITS'(zero_pos);
        m.marker_position = OUT_POS_BITS'(pos);
        m.kind = KIND_ONSET;
        expected_markers.insert(expected_markers.size(), m);
      end
      last_energy  = block_energy;
      block_energy = '0;
      zero_pos     = '0;
      zero_seen    = 1'b0;
      block_pos    = '0;
      block_start  = block_start + POS_BITS'(BLOCK_SIZE);
    end else begin
      block_pos = block_pos + 1'b1;
    end
    if (w.last) clear_buffer();
  endfunction

  // Called right after a rising edge; returns at the edge that took the word.
  task automatic send_sample(input in_word_t w);
    bit taken;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_marker(w);
    samples_sent++;
  endtask

  task automatic drain_markers();
    in_valid <= 1'b0;
    while (expected_markers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ENERGY_BITS-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_reg = value;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] level_sample(input int amp);
    int v;
    v = $urandom_range(1, amp);
    if ($urandom_range(0, 1)) v = -v;
    else if (v > 32767) v = 32767;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(1, 300);
    if (r < 8) return $urandom_range(8000, 32768);
    return $urandom_range(300, 8000);
  endfunction

  // one zero word in this many on average; 0 means none
  function automatic int pick_zero_odds();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 0;
    if (r == 1) return 8;
    if (r == 2) return 64;
    return 1024;
  endfunction

  // One block of random words within +-amp; zero_at < 0 means no zero word.
  task automatic send_block(input int amp, input int zero_at, input bit end_last);
    in_word_t w;
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      w.sample = (i == zero_at) ? '0 : level_sample(amp);
      w.last   = end_last && (i == BLOCK_SIZE - 1);
      send_sample(w);
    end
  endtask

  // 'big' words of value amp, then 'ones' words of 1, then zeros:
  // energy is big * amp * amp + ones.
  task automatic send_pattern_block(input int big, input int amp, input int ones,
                                    input bit end_last);
    in_word_t w;
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      if (i < big) w.sample = SAMPLE_BITS'(amp);
      else if (i < big + ones) w.sample = 16'sd1;
      else w.sample = 16'sd0;
      w.last = end_last && (i == BLOCK_SIZE - 1);
      send_sample(w);
    end
  endtask

  // Random run of words ending a buffer; levels shift now and then and the
  // last flag may also show up early.
  task automatic send_random_run(input int len);
    in_word_t w;
    int       amp;
    int       zero_odds;
    amp = pick_level();
    zero_odds = pick_zero_odds();
    for (int i = 0; i < len; i++) begin
      if (i != 0 && $urandom_range(0, BLOCK_SIZE - 1) == 0) amp = pick_level();
      w.sample = (zero_odds != 0 && $urandom_range(1, zero_odds) == 1) ?
                 '0 : level_sample(amp);
      w.last   = (i == len - 1) || ($urandom_range(0, 255) == 0);
      send_sample(w);
    end
  endtask

  task automatic test_start_markers();
    logic signed [SAMPLE_BITS-1:0] picks[7];
    in_word_t w;
    picks = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, 16'shaaaa};
    foreach (picks[i]) begin
      w.sample = picks[i];
      w.last   = 1'b1;
      send_sample(w);
    end
    w = '{sample: 16'sh0000, last: 1'b0};
    send_sample(w);
    w = '{sample: 16'sh8000, last: 1'b0};
    send_sample(w);
    w = '{sample: 16'sh7fff, last: 1'b1};
    send_sample(w);
    w = '{sample: 16'sh8000, last: 1'b0};
    send_sample(w);
    w = '{sample: 16'sh8000, last: 1'b1};
    send_sample(w);
    drain_markers();
  endtask

  task automatic test_energy_boundaries();
    write_threshold(ENERGY_BITS'(100));
    // energy equal to the threshold: no onset
    send_pattern_block(0, 0, 100, 1'b0);
    // one above ten times the previous block: onset
    send_pattern_block(250, 2, 1, 1'b0);
    // exactly ten times the previous block: no onset
    send_pattern_block(100, 10, 10, 1'b0);
    send_sample('{sample: 16'sd0, last: 1'b1});
    drain_markers();
  endtask

  task automatic test_last_block_unjudged();
    write_threshold(THRESHOLD_RESET);
    send_block(32768, 0, 1'b1);
    drain_markers();
  endtask

  task automatic test_receiver_hold();
    in_word_t w;
    hold_request = 1'b1;
    repeat (40) begin
      w.sample = SAMPLE_BITS'($urandom);
      w.last   = 1'b1;
      send_sample(w);
    end
    drain_markers();
  endtask

  task automatic test_random_buffers(input logic [ENERGY_BITS-1:0] thr, input int count);
    int stop_at;
    int room;
    int len;
    write_threshold(thr);
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      room = stop_at - samples_sent;
      len  = $urandom_range(1, 2 * BLOCK_SIZE);
      send_random_run((len < room) ? len : room);
    end
    drain_markers();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    test_random_buffers(THRESHOLD_RESET, 290);
  endtask

  // receiver side: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      out_stall  <= 1'b1;
      stall_left <= HOLD_CYCLES - 1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // inputs only move at rising edges, so the falling edge shows what the next edge takes
  always @(negedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_markers.size() == 0) begin
        $error("unexpected result word: marker_position %0d kind %0d",
               out_word.marker_position, out_word.kind);
        mismatches++;
      end else begin
        exp_word = expected_markers.pop_front();
        if (out_word.marker_position !== exp_word.marker_position) begin
          $error("marker_position: expected %0d, got %0d",
                 exp_word.marker_position, out_word.marker_position);
          mismatches++;
        end
        if (out_word.kind !== exp_word.kind) begin
          $error("kind: expected %0d, got %0d", exp_word.kind, out_word.kind);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    threshold_reg = THRESHOLD_RESET;
    clear_buffer();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_markers();
    test_energy_boundaries();
    test_last_block_unjudged();
    test_receiver_hold();
    test_random_buffers('0, 290);
    test_streaming();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* block_energy_onset_detector.f */
+incdir+design
design/bedo_pkg.sv
design/bedo_accum.sv
design/block_energy_onset_detector.sv
design/bedo_checker.sv
tb/sv/testbench.sv
